// ===== hdl/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg: shared constants of the trial-division primality tester
// Holds the fixed divisor schedule and the smallest prime.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

   // first trial divisor and the step between trial divisors
   localparam int unsigned FIRST_ODD_DIVISOR = 3;
   localparam int unsigned DIVISOR_STEP      = 2;

   // the only even prime
   localparam int unsigned SMALLEST_PRIME    = 2;

endpackage : ptd_pkg

`default_nettype wire

// ===== hdl/prime_test_trial_division_core.sv =====
// ----------------------------------------------------------------------------
// prime_test_trial_division_core: trial-division primality tester
// Takes one candidate on the req_ channel and returns one prime flag on the
// rsp_ channel. Both channels transfer when valid is high and stall is low.
// 0 and 1 give 0, 2 gives 1, other even numbers give 0. An odd candidate is
// divided by 3, 5, 7, ... with a bit-serial restoring divider, one quotient
// bit per cycle, until the divisor exceeds the quotient (prime) or a
// remainder is zero (not prime).
// The trivial cases go from the idle state straight to the done state;
// an odd candidate runs the divide and check states once per divisor
// tried. Worst case at 32 bits is about 32768 divisors.
// One candidate is worked on at a time; req_stall is high while it runs.
// A new candidate may be taken while the previous flag still waits on a
// stalled rsp_ channel; the result register holds until it transfers.
// Reset (synchronous, active high) drops any item in flight and clears
// rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_test_trial_division_core
   import ptd_pkg::*;
#(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [NUMBER_WIDTH-1:0] req_candidate,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_prime_flag
);

   localparam int CountWidth = $clog2(NUMBER_WIDTH);
   localparam logic [CountWidth-1:0] LastBit = CountWidth'(NUMBER_WIDTH - 1);
   localparam logic [NUMBER_WIDTH-1:0] FirstDivisor = NUMBER_WIDTH'(FIRST_ODD_DIVISOR);
   localparam logic [NUMBER_WIDTH-1:0] DivisorStep  = NUMBER_WIDTH'(DIVISOR_STEP);
   localparam logic [NUMBER_WIDTH-1:0] SmallPrime   = NUMBER_WIDTH'(SMALLEST_PRIME);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type               state_ff;
   logic [NUMBER_WIDTH-1:0] num_ff;
   logic [NUMBER_WIDTH-1:0] quo_ff;
   logic [NUMBER_WIDTH-1:0] rem_ff;
   logic [NUMBER_WIDTH-1:0] div_ff;
   logic [CountWidth-1:0]   cnt_ff;
   logic                    flag_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_flag_ff;

   logic [NUMBER_WIDTH:0]   trial;
   logic [NUMBER_WIDTH:0]   diff;
   logic                    fits;
   logic [NUMBER_WIDTH-1:0] rem_in;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? diff[NUMBER_WIDTH-1:0] : trial[NUMBER_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the done state reloads the result register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  num_ff <= req_candidate;
                  quo_ff <= req_candidate;
                  rem_ff <= '0;
                  div_ff <= FirstDivisor;
                  cnt_ff <= LastBit;
                  if (req_candidate < SmallPrime) begin
                     flag_ff  <= 1'b0;
                     state_ff <= ST_DONE;
                  end else if (req_candidate == SmallPrime) begin
                     flag_ff  <= 1'b1;
                     state_ff <= ST_DONE;
                  end else if (!req_candidate[0]) begin
                     flag_ff  <= 1'b0;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               // quotient bits shift in as dividend bits shift out
               quo_ff <= {quo_ff[NUMBER_WIDTH-2:0], fits};
               rem_ff <= rem_in;
               if (cnt_ff == '0) begin
                  state_ff <= ST_CHECK;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_CHECK: begin
               // divisor above quotient means divisor squared exceeds candidate
               if (div_ff > quo_ff) begin
                  flag_ff  <= 1'b1;
                  state_ff <= ST_DONE;
               end else if (rem_ff == '0) begin
                  flag_ff  <= 1'b0;
                  state_ff <= ST_DONE;
               end else begin
                  div_ff   <= div_ff + DivisorStep;
                  quo_ff   <= num_ff;
                  rem_ff   <= '0;
                  cnt_ff   <= LastBit;
                  state_ff <= ST_DIV;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_flag_ff  <= flag_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prime_flag = rsp_flag_ff;

`ifndef ASSERT_OFF
   // a new result only ever comes out of the done state
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

   // trial divisors stay odd
   a_divisor_odd : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_CHECK) |-> div_ff[0])
      else $error("even trial divisor");

   // restoring division keeps the partial remainder below the divisor
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_CHECK) |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");

   // an accepted candidate always starts work
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DIV || state_ff == ST_DONE))
      else $error("accepted candidate did not start");
`endif

endmodule : prime_test_trial_division_core

`default_nettype wire
